// ===== rtl/slfl_pkg.sv =====
package slfl_pkg;

  localparam int SLOTS    = 64;
  localparam int ADDR_W   = $clog2(SLOTS);
  localparam int IDX_W    = $clog2(SLOTS + 1);
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  // index one past the last slot marks the end of a chain
  localparam idx_t NIL = IDX_W'(SLOTS);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_WALK,
    S_WR_A,
    S_WR_B,
    S_DONE
  } state_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } rd_req_t;

  typedef struct packed {
    logic   we;
    addr_t  addr;
    value_t data;
  } val_wr_t;

  typedef struct packed {
    logic  we;
    addr_t addr;
    idx_t  data;
  } nxt_wr_t;

endpackage

// ===== rtl/slfl_if.sv =====
interface slfl_in_if;
  import slfl_pkg::*;

  logic   valid;
  logic   ready;
  logic   cmd;
  value_t value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface slfl_out_if;
  import slfl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  element_count;

  modport source (output valid, output status, output element_count, input ready);
  modport sink   (input valid, input status, input element_count, output ready);
endinterface

// ===== rtl/slfl_store.sv =====
module slfl_store (
  input  logic              clk,
  input  logic              rst,
  input  slfl_pkg::rd_req_t rd,
  input  slfl_pkg::val_wr_t val_wr,
  input  slfl_pkg::nxt_wr_t nxt_wr,
  output slfl_pkg::value_t  rd_value,
  output slfl_pkg::idx_t    rd_link
);
  import slfl_pkg::*;

  value_t             val_mem [SLOTS];
  idx_t               nxt_mem [SLOTS];
  logic [SLOTS-1:0]   nxt_vld;
  addr_t              rd_idx;
  idx_t               nxt_q;
  idx_t               link_raw;

  // value store: no reset, only values of listed slots are ever used
  always_ff @(posedge clk) begin
    if (val_wr.we) begin
      val_mem[val_wr.addr] <= val_wr.data;
    end
    if (rd.en) begin
      rd_value <= val_mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_wr.we) begin
      nxt_mem[nxt_wr.addr] <= nxt_wr.data;
    end
    if (rd.en) begin
      nxt_q  <= nxt_mem[rd.addr];
      rd_idx <= rd.addr;
    end
  end

  // unwritten link entries read as the reset chain i -> i+1
  always_ff @(posedge clk) begin
    if (rst) begin
      nxt_vld <= '0;
    end else if (nxt_wr.we) begin
      nxt_vld[nxt_wr.addr] <= 1'b1;
    end
  end

  always_comb begin
    link_raw = nxt_vld[rd_idx] ? nxt_q : IDX_W'(rd_idx) + IDX_W'(1);
    rd_link  = (link_raw < NIL) ? link_raw : NIL;
  end

endmodule

// ===== rtl/sorted_list_with_free_list_core.sv =====
// Channel | Dir | Payload                       | Transfer
// --------+-----+-------------------------------+--------------------------
// req     | in  | cmd (1b), value (32b signed)  | valid & ready, one op
// rsp     | out | status (2b), element_count(7b)| valid & ready, one result
//
// Ops: one op at a time. An insert steps FREE, WALK (none on an empty list),
//   WR_A, WR_B (none at the list head), DONE; a remove that finds its value steps
//   WALK, WR_A, WR_B (likewise), DONE; one that misses WALK, DONE. The walk
//   reads at most 64 list elements, one slot per cycle from the shared slot
//   store read port; a full-store insert or an empty-list remove skips to DONE.
// Reset: synchronous; list empty, free chain 0..63 in order, no clearing
//   pass (link entries carry valid bits cleared by reset).
// Stalls: a result waits in the rsp register; req is taken again once the
//   op is done, while that result may still be pending.
module sorted_list_with_free_list_core (
  input logic        clk,
  input logic        rst,
  slfl_in_if.sink    req,
  slfl_out_if.source rsp
);
  import slfl_pkg::*;

  state_t  state, state_next;
  idx_t    list_head, list_head_next;
  idx_t    free_head, free_head_next;
  idx_t    count, count_next;
  logic    op, op_next;
  value_t  key, key_next;
  addr_t   new_slot, new_slot_next;
  idx_t    prev, prev_next;
  idx_t    cur, cur_next;
  idx_t    succ, succ_next;
  status_t status, status_next;

  logic                rsp_valid, rsp_valid_next;
  logic [STATUS_W-1:0] rsp_status, rsp_status_next;
  logic [COUNT_W-1:0]  rsp_count, rsp_count_next;

  rd_req_t rd;
  val_wr_t val_wr;
  nxt_wr_t nxt_wr;
  value_t  rd_value;
  idx_t    rd_link;

  logic advance;
  logic link_nil;
  logic rsp_free;

  slfl_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd       (rd),
    .val_wr   (val_wr),
    .nxt_wr   (nxt_wr),
    .rd_value (rd_value),
    .rd_link  (rd_link)
  );

  // insert walks past smaller values, remove walks past unequal ones
  assign advance  = (op == CMD_INSERT) ? (rd_value < key) : (rd_value != key);
  assign link_nil = (rd_link == NIL);
  assign rsp_free = !rsp_valid || rsp.ready;

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.element_count = rsp_count;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.cmd == CMD_INSERT) begin
            state_next = (free_head == NIL) ? S_DONE : S_FREE;
          end else begin
            state_next = (list_head == NIL) ? S_DONE : S_WALK;
          end
        end
      end
      S_FREE: begin
        state_next = (list_head == NIL) ? S_WR_A : S_WALK;
      end
      S_WALK: begin
        if (advance && !link_nil) begin
          state_next = S_WALK;
        end else if (advance && op == CMD_REMOVE) begin
          state_next = S_DONE;
        end else begin
          state_next = S_WR_A;
        end
      end
      S_WR_A: begin
        state_next = (prev == NIL) ? S_DONE : S_WR_B;
      end
      S_WR_B: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // datapath, store accesses and result register
  always_comb begin
    list_head_next  = list_head;
    free_head_next  = free_head;
    count_next      = count;
    op_next         = op;
    key_next        = key;
    new_slot_next   = new_slot;
    prev_next       = prev;
    cur_next        = cur;
    succ_next       = succ;
    status_next     = status;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_status_next = rsp_status;
    rsp_count_next  = rsp_count;
    rd              = '0;
    val_wr          = '0;
    nxt_wr          = '0;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_next     = req.cmd;
          key_next    = req.value;
          prev_next   = NIL;
          status_next = ST_DONE;
          if (req.cmd == CMD_INSERT) begin
            if (free_head == NIL) begin
              status_next = ST_FULL;
            end else begin
              new_slot_next = addr_t'(free_head);
              val_wr.we     = 1'b1;
              val_wr.addr   = addr_t'(free_head);
              val_wr.data   = req.value;
              rd.en         = 1'b1;
              rd.addr       = addr_t'(free_head);
            end
          end else begin
            cur_next = list_head;
            if (list_head == NIL) begin
              status_next = ST_MISS;
            end else begin
              rd.en   = 1'b1;
              rd.addr = addr_t'(list_head);
            end
          end
        end
      end
      S_FREE: begin
        // pop the free head, start the walk at the list head
        free_head_next = rd_link;
        cur_next       = list_head;
        if (list_head != NIL) begin
          rd.en   = 1'b1;
          rd.addr = addr_t'(list_head);
        end
      end
      S_WALK: begin
        if (advance) begin
          prev_next = cur;
          cur_next  = rd_link;
          if (link_nil) begin
            if (op == CMD_REMOVE) begin
              status_next = ST_MISS;
            end
          end else begin
            rd.en   = 1'b1;
            rd.addr = addr_t'(rd_link);
          end
        end else begin
          succ_next = rd_link;
        end
      end
      S_WR_A: begin
        nxt_wr.we = 1'b1;
        if (op == CMD_INSERT) begin
          nxt_wr.addr = new_slot;
          nxt_wr.data = cur;
          count_next  = count + IDX_W'(1);
          if (prev == NIL) begin
            list_head_next = IDX_W'(new_slot);
          end
        end else begin
          // freed slot goes on top of the free list
          nxt_wr.addr    = addr_t'(cur);
          nxt_wr.data    = free_head;
          free_head_next = cur;
          count_next     = count - IDX_W'(1);
          if (prev == NIL) begin
            list_head_next = succ;
          end
        end
      end
      S_WR_B: begin
        nxt_wr.we   = 1'b1;
        nxt_wr.addr = addr_t'(prev);
        nxt_wr.data = (op == CMD_INSERT) ? IDX_W'(new_slot) : succ;
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = status;
          rsp_count_next  = COUNT_W'(count);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      list_head <= NIL;
      free_head <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      list_head <= list_head_next;
      free_head <= free_head_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    key        <= key_next;
    new_slot   <= new_slot_next;
    prev       <= prev_next;
    cur        <= cur_next;
    succ       <= succ_next;
    status     <= status_next;
    rsp_status <= rsp_status_next;
    rsp_count  <= rsp_count_next;
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= NIL)
    else $error("element count beyond store size");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second op taken while one is in flight");

  a_free_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> ((free_head == NIL) == (count == NIL)))
    else $error("free list state disagrees with element count");

  a_list_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> ((list_head == NIL) == (count == '0)))
    else $error("list head disagrees with element count");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside of completion");
`endif

endmodule

// ===== test/sorted_list_with_free_list_core_test.sv =====
module sorted_list_with_free_list_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import slfl_pkg::*;

  // Run length guard, far above the slowest legal run (~1.5k ops plus sender gaps,
  // receiver stalls and the long hold-off).
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_OPS  = 1500;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_PCT    = 31;
  localparam value_t VMIN = value_t'(32'h8000_0000);
  localparam value_t VMAX = value_t'(32'h7fff_ffff);

  // Stimulus flavor of one random phase.
  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } mode_t;

  // Shadow copy of the slot store: predicts status and count for each op
  // as it is accepted, and queues the expectation for the response side.
  class sorted_list_checker;
    typedef struct {
      status_t            st;
      logic [COUNT_W-1:0] cnt;
    } result_t;

    value_t      slot_val [SLOTS];
    idx_t        slot_nxt [SLOTS];
    idx_t        head;
    idx_t        free_top;
    int unsigned live;
    result_t     pending_results [$];
    int unsigned mismatches;
    int unsigned placed, dropped, removed, missed, peak;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_val[addr_t'(i)] = '0;
        slot_nxt[addr_t'(i)] = idx_t'(i + 1);
      end
      head       = NIL;
      free_top   = '0;
      live       = 0;
      mismatches = 0;
      placed     = 0;
      dropped    = 0;
      removed    = 0;
      missed     = 0;
      peak       = 0;
    endfunction

    function void note_op(cmd_t op, value_t v);
      idx_t    slot, prev, cur;
      result_t r;
      prev = NIL;
      cur  = head;
      if (op == CMD_INSERT) begin
        if (free_top == NIL) begin
          r.st = ST_FULL;
          dropped++;
        end else begin
          slot                   = free_top;
          free_top               = slot_nxt[addr_t'(slot)];
          slot_val[addr_t'(slot)] = v;
          // stop at first element not smaller: new value lands before equals
          while (cur != NIL && slot_val[addr_t'(cur)] < v) begin
            prev = cur;
            cur  = slot_nxt[addr_t'(cur)];
          end
          slot_nxt[addr_t'(slot)] = cur;
          if (prev == NIL) head = slot;
          else slot_nxt[addr_t'(prev)] = slot;
          live++;
          placed++;
          if (live > peak) peak = live;
          r.st = ST_DONE;
        end
      end else begin
        while (cur != NIL && slot_val[addr_t'(cur)] != v) begin
          prev = cur;
          cur  = slot_nxt[addr_t'(cur)];
        end
        if (cur == NIL) begin
          r.st = ST_MISS;
          missed++;
        end else begin
          if (prev == NIL) head = slot_nxt[addr_t'(cur)];
          else slot_nxt[addr_t'(prev)] = slot_nxt[addr_t'(cur)];
          slot_nxt[addr_t'(cur)] = free_top;
          free_top               = cur;
          live--;
          removed++;
          r.st = ST_DONE;
        end
      end
      r.cnt = COUNT_W'(live);
      pending_results.push_back(r);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt);
      result_t want;
      if (pending_results.size() == 0) begin
        flag($sformatf("result with no op outstanding: status %0d count %0d", st, cnt));
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.st)
        flag($sformatf("status expected %0d got %0d", want.st, st));
      if (cnt !== want.cnt)
        flag($sformatf("element_count expected %0d got %0d", want.cnt, cnt));
    endfunction

    // A value currently in the list, so removes hit often.
    function value_t some_live_value();
      idx_t        cur;
      int unsigned k;
      if (live == 0) return value_t'($urandom);
      k   = $urandom_range(live - 1);
      cur = head;
      repeat (k) cur = slot_nxt[addr_t'(cur)];
      return slot_val[addr_t'(cur)];
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  slfl_in_if  req_ch ();
  slfl_out_if rsp_ch ();

  sorted_list_with_free_list_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sorted_list_checker shadow_list = new();

  int unsigned cycle_count  = 0;
  int unsigned sent_ops     = 0;
  bit          steady       = 1'b0;  // both sides stop idling while set
  bit          hold_request = 1'b0;  // asks the response side for a long stall

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               shadow_list.pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Monitor: predict on every request transfer, check every response transfer.
  // Signals are sampled at the edge, before this edge's updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        shadow_list.note_op(cmd_t'(req_ch.cmd), req_ch.value);
      if (rsp_ch.valid && rsp_ch.ready)
        shadow_list.check_result(rsp_ch.status, rsp_ch.element_count);
    end
  end

  // Response side: random backpressure, plus one long hold-off on request so
  // a result parks in the output register and the core stops taking ops.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // One request transfer. Valid stays high across back-to-back ops; it only
  // drops when a gap is taken, so each step sees a single assignment to it.
  task automatic send_op(cmd_t op, value_t v);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= op;
    req_ch.value <= v;
    do @(posedge clk); while (!req_ch.ready);
    sent_ops++;
  endtask

  // Sender pause until every outstanding result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (shadow_list.pending_results.size() != 0);
  endtask

  function automatic value_t pool_value();
    return value_t'(int'($urandom_range(15)) - 8);
  endfunction

  function automatic value_t insert_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return pool_value();
    if (r < 55) begin
      case ($urandom_range(3))
        0:       return VMIN;
        1:       return VMAX;
        2:       return value_t'(0);
        default: return value_t'(-1);
      endcase
    end
    return value_t'($urandom);
  endfunction

  function automatic value_t remove_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return shadow_list.some_live_value();
    if (r < 80) return pool_value();
    return value_t'($urandom);
  endfunction

  task automatic run_phase(mode_t mode, int unsigned n_ops);
    int unsigned ins_pct;
    case (mode)
      MODE_FILL:  ins_pct = 85;
      MODE_DRAIN: ins_pct = 15;
      default:    ins_pct = 50;
    endcase
    repeat (n_ops) begin
      if ($urandom_range(99) < ins_pct) send_op(CMD_INSERT, insert_value());
      else send_op(CMD_REMOVE, remove_value());
    end
  endtask

  initial begin
    int unsigned phase, rand_ops, n_ops;
    mode_t       mode;

    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.cmd   <= CMD_INSERT;
    req_ch.value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list remove, extremes, duplicates ordered and removed
    // newest first, misses on a populated list, alternating bit patterns.
    send_op(CMD_REMOVE, value_t'(5));
    send_op(CMD_INSERT, value_t'(0));
    send_op(CMD_INSERT, value_t'(-1));
    send_op(CMD_INSERT, VMAX);
    send_op(CMD_INSERT, VMIN);
    send_op(CMD_INSERT, value_t'(0));
    send_op(CMD_INSERT, value_t'(0));
    send_op(CMD_INSERT, value_t'(7));
    send_op(CMD_REMOVE, value_t'(3));
    send_op(CMD_REMOVE, value_t'(0));
    send_op(CMD_REMOVE, VMIN);
    send_op(CMD_REMOVE, VMAX);
    send_op(CMD_REMOVE, value_t'(-1));
    send_op(CMD_INSERT, value_t'(32'h5555_5555));
    send_op(CMD_INSERT, value_t'(32'haaaa_aaaa));
    send_op(CMD_REMOVE, value_t'(0));
    send_op(CMD_REMOVE, value_t'(0));
    send_op(CMD_REMOVE, value_t'(0));
    send_op(CMD_REMOVE, value_t'(7));
    send_op(CMD_REMOVE, value_t'(32'h5555_5555));
    send_op(CMD_REMOVE, value_t'(32'haaaa_aaaa));
    send_op(CMD_INSERT, VMIN);
    send_op(CMD_INSERT, VMIN);
    send_op(CMD_REMOVE, VMIN);
    send_op(CMD_REMOVE, VMIN);
    drain_results();

    // Random phases. First two are fixed: fill well past capacity so the
    // full-store drop shows up, then drain past empty. Phase 2 carries the
    // long response hold-off; phase 4 runs with no idling on either side.
    phase    = 0;
    rand_ops = 0;
    while (rand_ops < RANDOM_OPS) begin
      case (phase)
        0: begin
          mode  = MODE_FILL;
          n_ops = 100;
        end
        1: begin
          mode  = MODE_DRAIN;
          n_ops = 100;
        end
        default: begin
          mode  = mode_t'($urandom_range(2));
          n_ops = $urandom_range(120, 30);
        end
      endcase
      if (phase == 2) hold_request = 1'b1;
      steady = (phase == 4);
      run_phase(mode, n_ops);
      rand_ops += n_ops;
      if (phase == 1 || $urandom_range(2) == 0) drain_results();
      phase++;
    end
    steady = 1'b0;

    drain_results();
    // idle tail, in case anything stray trails the last result
    repeat (80) @(posedge clk);

    $display("ran %0d ops over %0d phases: %0d placed, %0d dropped full, %0d removed, %0d missed",
             sent_ops, phase, shadow_list.placed, shadow_list.dropped,
             shadow_list.removed, shadow_list.missed);
    $display("peak list size %0d, %0d mismatches, %0d results never seen",
             shadow_list.peak, shadow_list.mismatches, shadow_list.pending_results.size());
    if (shadow_list.mismatches == 0 && shadow_list.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
